[src/cor_pkg.sv]
package cor_pkg;

  localparam int RADIUS_BITS = 6;
  localparam int COORD_BITS  = 12;
  localparam int OUT_BITS    = COORD_BITS + 1;
  localparam int ERR_BITS    = 2 * RADIUS_BITS + 3;

  localparam logic signed [ERR_BITS-1:0] ERR_ONE = ERR_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CENTER,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic load_in;
    logic load_center;
    logic load_walk;
  } cmd_t;

  typedef struct packed {
    logic radius_zero;
    logic walk_last;
    logic out_blocked;
  } stat_t;

endpackage

[src/cor_ctrl.sv]
module cor_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cor_pkg::stat_t stat,
  output cor_pkg::cmd_t  cmd
);

  cor_pkg::state_t state_r;
  cor_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cor_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cor_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cor_pkg::ST_CENTER;
        end
      end
      cor_pkg::ST_CENTER: begin
        if (!stat.out_blocked) begin
          state_nxt = stat.radius_zero ? cor_pkg::ST_IDLE : cor_pkg::ST_WALK;
        end
      end
      cor_pkg::ST_WALK: begin
        if (!stat.out_blocked && stat.walk_last) begin
          state_nxt = cor_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cor_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    cmd.load_in     = 1'b0;
    cmd.load_center = 1'b0;
    cmd.load_walk   = 1'b0;
    case (state_r)
      cor_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      cor_pkg::ST_CENTER: begin
        cmd.load_center = !stat.out_blocked;
      end
      cor_pkg::ST_WALK: begin
        cmd.load_walk = !stat.out_blocked;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[src/cor_dp.sv]
module cor_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [cor_pkg::COORD_BITS-1:0] in_center_x,
  input  logic signed [cor_pkg::COORD_BITS-1:0] in_center_y,
  input  logic [cor_pkg::RADIUS_BITS-1:0]       in_radius,
  input  cor_pkg::cmd_t                         cmd,
  output cor_pkg::stat_t                        stat,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_is_center,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_x_far_plus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_x_far_minus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_x_near_plus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_x_near_minus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_y_near_plus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_y_near_minus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_y_far_plus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_y_far_minus,
  output logic                                  out_last
);

  localparam int RB = cor_pkg::RADIUS_BITS;
  localparam int CB = cor_pkg::COORD_BITS;
  localparam int OB = cor_pkg::OUT_BITS;
  localparam int EB = cor_pkg::ERR_BITS;

  logic signed [CB-1:0] cx_r;
  logic signed [CB-1:0] cy_r;
  logic [RB-1:0]        wx_r;
  logic [RB-1:0]        wy_r;
  logic signed [EB-1:0] err_r;

  logic signed [EB-1:0] xs;
  logic signed [EB-1:0] ys;
  logic signed [EB-1:0] err_x;
  logic signed [EB-1:0] err_y;
  logic [EB-1:0]        abs_x;
  logic [EB-1:0]        abs_y;
  logic                 step_x;
  logic [RB-1:0]        wx_nxt;
  logic [RB-1:0]        wy_nxt;
  logic signed [EB-1:0] err_nxt;

  logic signed [OB-1:0] cx_e;
  logic signed [OB-1:0] cy_e;
  logic signed [OB-1:0] ox_e;
  logic signed [OB-1:0] oy_e;

  logic                 out_valid_r;
  logic                 out_valid_nxt;

  // The running error holds x*x + y*y - r*r, so each candidate is one add away.
  assign xs     = signed'({{(EB-RB){1'b0}}, wx_r});
  assign ys     = signed'({{(EB-RB){1'b0}}, wy_r});
  assign err_x  = err_r - (xs <<< 1) + cor_pkg::ERR_ONE;
  assign err_y  = err_r + (ys <<< 1) + cor_pkg::ERR_ONE;
  assign abs_x  = err_x[EB-1] ? EB'(-err_x) : EB'(err_x);
  assign abs_y  = err_y[EB-1] ? EB'(-err_y) : EB'(err_y);
  assign step_x = abs_x < abs_y;

  assign wx_nxt  = step_x ? wx_r - RB'(1) : wx_r;
  assign wy_nxt  = step_x ? wy_r : wy_r + RB'(1);
  assign err_nxt = step_x ? err_x : err_y;

  assign cx_e = signed'({cx_r[CB-1], cx_r});
  assign cy_e = signed'({cy_r[CB-1], cy_r});
  assign ox_e = signed'({{(OB-RB){1'b0}}, wx_r});
  assign oy_e = signed'({{(OB-RB){1'b0}}, wy_r});

  assign stat.radius_zero = (wx_r == '0);
  assign stat.walk_last   = (wx_nxt <= wy_nxt);
  assign stat.out_blocked = out_valid_r && out_stall;

  always_comb begin
    if (cmd.load_center || cmd.load_walk) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cx_r  <= in_center_x;
      cy_r  <= in_center_y;
      wx_r  <= in_radius;
      wy_r  <= '0;
      err_r <= '0;
    end else if (cmd.load_walk) begin
      wx_r  <= wx_nxt;
      wy_r  <= wy_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_center) begin
      out_is_center    <= 1'b1;
      out_x_far_plus   <= cx_e;
      out_x_far_minus  <= cx_e;
      out_x_near_plus  <= cx_e;
      out_x_near_minus <= cx_e;
      out_y_near_plus  <= cy_e;
      out_y_near_minus <= cy_e;
      out_y_far_plus   <= cy_e;
      out_y_far_minus  <= cy_e;
      out_last         <= stat.radius_zero;
    end else if (cmd.load_walk) begin
      out_is_center    <= 1'b0;
      out_x_far_plus   <= cx_e + ox_e;
      out_x_far_minus  <= cx_e - ox_e;
      out_x_near_plus  <= cx_e + oy_e;
      out_x_near_minus <= cx_e - oy_e;
      out_y_near_plus  <= cy_e + oy_e;
      out_y_near_minus <= cy_e - oy_e;
      out_y_far_plus   <= cy_e + ox_e;
      out_y_far_minus  <= cy_e - ox_e;
      out_last         <= stat.walk_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/circle_octant_rasterizer.sv]
// Channel  Direction  Handshake         Payload
// in_      input      in_valid/stall    center_x, center_y, radius
// out_     output     out_valid/stall   is_center, eight coordinates, last
//
// A circle gives a centre transaction, then one per octant walk point until x no
// longer exceeds y, one per cycle when the output is not stalled; the next input
// is taken once the controller is back in idle. Radius zero gives only the centre.
// The octant walk register set is shared, so one circle is worked at a time.
// A new input is taken while the final result still waits in the output register.
// Reset is synchronous and active low; it clears the controller and output valid.
// An output stall holds the result register and pauses the walk.
module circle_octant_rasterizer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [cor_pkg::COORD_BITS-1:0] in_center_x,
  input  logic signed [cor_pkg::COORD_BITS-1:0] in_center_y,
  input  logic [cor_pkg::RADIUS_BITS-1:0]       in_radius,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_is_center,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_x_far_plus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_x_far_minus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_x_near_plus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_x_near_minus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_y_near_plus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_y_near_minus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_y_far_plus,
  output logic signed [cor_pkg::OUT_BITS-1:0]   out_y_far_minus,
  output logic                                  out_last
);

  cor_pkg::cmd_t  cmd;
  cor_pkg::stat_t stat;

  cor_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cor_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius        (in_radius),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_center    (out_is_center),
    .out_x_far_plus   (out_x_far_plus),
    .out_x_far_minus  (out_x_far_minus),
    .out_x_near_plus  (out_x_near_plus),
    .out_x_near_minus (out_x_near_minus),
    .out_y_near_plus  (out_y_near_plus),
    .out_y_near_minus (out_y_near_minus),
    .out_y_far_plus   (out_y_far_plus),
    .out_y_far_minus  (out_y_far_minus),
    .out_last         (out_last)
  );

endmodule

[src/cor_checker.sv]
module cor_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic                                  out_is_center,
  input logic signed [cor_pkg::OUT_BITS-1:0]   out_x_far_plus,
  input logic signed [cor_pkg::OUT_BITS-1:0]   out_x_far_minus,
  input logic signed [cor_pkg::OUT_BITS-1:0]   out_x_near_minus,
  input logic signed [cor_pkg::OUT_BITS-1:0]   out_y_far_plus,
  input logic signed [cor_pkg::OUT_BITS-1:0]   out_y_near_minus,
  input logic                                  out_last
);

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid set straight after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the circle was started");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_far_plus) && $stable(out_last))
    else $error("stalled output transaction changed");

  a_center_coords_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_center |->
      out_x_far_plus == out_x_near_minus && out_y_far_plus == out_y_near_minus)
    else $error("centre result coordinates differ");

  a_walk_offset_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_center |-> out_x_far_plus != out_x_far_minus)
    else $error("walk result with zero x offset");

endmodule

bind circle_octant_rasterizer cor_checker u_cor_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_is_center    (out_is_center),
  .out_x_far_plus   (out_x_far_plus),
  .out_x_far_minus  (out_x_far_minus),
  .out_x_near_minus (out_x_near_minus),
  .out_y_far_plus   (out_y_far_plus),
  .out_y_near_minus (out_y_near_minus),
  .out_last         (out_last)
);
